// ----- rtl/mdn_pkg.sv -----
// Shared constants, types and control structures of the sliding median block.
package mdn_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int CHANNEL_W        = 3;
  localparam int LEN_W            = 4;
  localparam int CHANNELS_DEF     = 4;
  localparam int WINDOW_LIMIT_DEF = 11;

  // Digit-serial selection: two bits of every lane are resolved per step.
  localparam int DIGIT_W = 2;
  localparam int RADIX   = 1 << DIGIT_W;
  localparam int STEPS   = SAMPLE_W / DIGIT_W;
  localparam int STEP_W  = $clog2(STEPS);

  // Flipping the sign bit turns a signed order into an unsigned one.
  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FLUSH,
    ST_SELECT,
    ST_DONE
  } mdn_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mdn_store_ctrl_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic step;
  } mdn_sel_ctrl_t;

endpackage

// ----- rtl/mdn_if.sv -----
// Valid/ready channel interfaces for input samples and median results.
interface mdn_in_if;
  import mdn_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [CHANNEL_W-1:0]        channel;
  logic [LEN_W-1:0]            window_len;
  logic signed [SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output window_len, output sample,
                  input ready);
  modport sink   (input valid, input channel, input window_len, input sample,
                  output ready);
endinterface

interface mdn_out_if;
  import mdn_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  median;
  logic                        invalid;

  modport source (output valid, output median, output invalid, input ready);
  modport sink   (input valid, input median, input invalid, output ready);
endinterface

// ----- rtl/mdn_store.sv -----
// Per-channel sample memory with valid bits and ring write pointers.
module mdn_store #(
  parameter int CHANNELS     = mdn_pkg::CHANNELS_DEF,
  parameter int WINDOW_LIMIT = mdn_pkg::WINDOW_LIMIT_DEF,
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int WIN_W = $clog2(WINDOW_LIMIT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdn_pkg::mdn_store_ctrl_t      ctrl,
  input  logic [CH_W-1:0]               ch,
  input  logic [mdn_pkg::LEN_W-1:0]     len,
  input  logic [mdn_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic [WIN_W-1:0]              rd_idx,
  output logic [mdn_pkg::SAMPLE_W-1:0]  rd_data,
  output logic                          rd_valid
);
  import mdn_pkg::*;

  logic [SAMPLE_W-1:0] mem [CHANNELS][WINDOW_LIMIT];
  logic                vld_r [CHANNELS][WINDOW_LIMIT];
  logic [WIN_W-1:0]    ptr_r [CHANNELS];
  logic [SAMPLE_W-1:0] mem_q_r;
  logic                vld_q_r;
  logic                rd_valid_r;
  logic [WIN_W:0]      ptr_inc;
  logic [WIN_W-1:0]    wr_idx;

  // The pointer advances first and wraps once it reaches the window length.
  assign ptr_inc = {1'b0, ptr_r[ch]} + (WIN_W+1)'(1);
  assign wr_idx  = (32'(ptr_inc) >= 32'(len)) ? '0 : ptr_inc[WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '{default: '0};
      vld_r      <= '{default: 1'b0};
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= ctrl.rd_en;
      if (ctrl.wr_en) begin
        ptr_r[ch]        <= wr_idx;
        vld_r[ch][wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ch][wr_idx] <= wr_data;
    end
    if (ctrl.rd_en) begin
      mem_q_r <= mem[ch][rd_idx];
      vld_q_r <= vld_r[ch][rd_idx];
    end
  end

  // Slots never written since reset read as zero.
  assign rd_data  = vld_q_r ? mem_q_r : '0;
  assign rd_valid = rd_valid_r;

endmodule

// ----- rtl/mdn_select.sv -----
// Lane shift registers and radix-4 digit-serial rank selection.
module mdn_select #(
  parameter int WINDOW_LIMIT = mdn_pkg::WINDOW_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdn_pkg::mdn_sel_ctrl_t        ctrl,
  input  logic [mdn_pkg::LEN_W-1:0]     len,
  input  logic [mdn_pkg::SAMPLE_W-1:0]  shift_data,
  output logic [mdn_pkg::SAMPLE_W-1:0]  result
);
  import mdn_pkg::*;

  localparam int LANES = WINDOW_LIMIT - 1;
  localparam int CNT_W = $clog2(LANES + 1);

  logic [SAMPLE_W-1:0] lane_r [LANES];
  logic [LANES-1:0]    act_r;
  logic [LANES-1:0]    act_nxt;
  logic [LANES-1:0]    cand_r;
  logic [LANES-1:0]    cand_nxt;
  logic [CNT_W-1:0]    k_r;
  logic [CNT_W-1:0]    k_nxt;
  logic [SAMPLE_W-1:0] res_r;
  logic [CNT_W-1:0]    cnt [RADIX];
  logic [CNT_W-1:0]    base;
  logic [DIGIT_W-1:0]  dig;
  logic                found;

  // Count the candidates that carry each digit value in the top position,
  // then walk the cumulative counts to find the digit that holds rank k.
  always_comb begin
    for (int v = 0; v < RADIX; v++) begin
      cnt[v] = '0;
      for (int j = 0; j < LANES; j++) begin
        if (cand_r[j] && (lane_r[j][SAMPLE_W-1 -: DIGIT_W] == DIGIT_W'(v))) begin
          cnt[v] = cnt[v] + CNT_W'(1);
        end
      end
    end
    base  = '0;
    found = 1'b0;
    dig   = DIGIT_W'(RADIX - 1);
    for (int v = 0; v < RADIX - 1; v++) begin
      if (!found) begin
        if (k_r < base + cnt[v]) begin
          found = 1'b1;
          dig   = DIGIT_W'(v);
        end else begin
          base = base + cnt[v];
        end
      end
    end
    k_nxt = k_r - base;
    for (int j = 0; j < LANES; j++) begin
      cand_nxt[j] = cand_r[j] && (lane_r[j][SAMPLE_W-1 -: DIGIT_W] == dig);
    end
    act_nxt[0] = 1'b1;
    for (int j = 1; j < LANES; j++) begin
      act_nxt[j] = act_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      cand_r <= '0;
      k_r    <= '0;
    end else if (ctrl.clear) begin
      act_r  <= '0;
      cand_r <= '0;
      k_r    <= CNT_W'(len >> 1);
    end else if (ctrl.shift) begin
      act_r  <= act_nxt;
      cand_r <= act_nxt;
    end else if (ctrl.step) begin
      cand_r <= cand_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      lane_r[0] <= shift_data ^ SIGN_FLIP;
      for (int j = 1; j < LANES; j++) begin
        lane_r[j] <= lane_r[j-1];
      end
    end else if (ctrl.step) begin
      for (int j = 0; j < LANES; j++) begin
        lane_r[j] <= {lane_r[j][SAMPLE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
      res_r <= {res_r[SAMPLE_W-DIGIT_W-1:0], dig};
    end
  end

  assign result = res_r ^ SIGN_FLIP;

endmodule

// ----- rtl/multichannel_sliding_median_top.sv -----
// Top level of the multichannel sliding-window median filter.
//
// Usage: every transaction on the input channel (in_ch) carries a channel
// number, a window length and a signed Q16.16 sample; each one produces
// exactly one transaction on the result channel (out_ch) with the median of
// that channel's window, or zero with the invalid flag set when the channel
// is not below CHANNELS or the length is zero or not below WINDOW_LIMIT.
// A valid item is taken in the idle state and then keeps the block busy
// while it reads window_len slots from the sample memory (one memory read
// port), passes the flush state, runs 16 selection steps of two bits each
// and hands the result to the output register. An invalid item goes straight
// to the handover. The next transaction is taken only once the handover is
// done and the block is idle again. One item is processed at a time.
// Reset is synchronous and active low; it zeroes the write pointers and the
// memory valid bits, so every sample slot reads as zero until written.
// While the receiver stalls the result stays in the output register and
// the next item is still taken and processed; only its final handover waits
// until the register has been emptied.
module multichannel_sliding_median_top #(
  parameter int CHANNELS     = mdn_pkg::CHANNELS_DEF,
  parameter int WINDOW_LIMIT = mdn_pkg::WINDOW_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mdn_in_if.sink       in_ch,
  mdn_out_if.source    out_ch
);
  import mdn_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_W = $clog2(WINDOW_LIMIT);

  mdn_state_t          state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                inv_r, inv_nxt;
  logic [WIN_W-1:0]    idx_r, idx_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] median_r, median_nxt;
  logic                invalid_r, invalid_nxt;
  logic                out_load;

  logic                accept;
  logic                in_ok;
  logic [CH_W-1:0]     store_ch;
  mdn_store_ctrl_t     store_ctrl;
  mdn_sel_ctrl_t       sel_ctrl;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_valid;
  logic [SAMPLE_W-1:0] sel_result;

  // Input checks: the channel must exist and the length must lie in range.
  assign in_ok = (32'(in_ch.channel) < CHANNELS) && (in_ch.window_len != '0) &&
                 (32'(in_ch.window_len) < WINDOW_LIMIT);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // The write happens in the accepting cycle; reads use the captured channel.
  assign store_ch         = (state_r == ST_IDLE) ? CH_W'(in_ch.channel) : ch_r;
  assign store_ctrl.wr_en = accept && in_ok;
  assign store_ctrl.rd_en = (state_r == ST_LOAD);

  assign sel_ctrl.clear = accept && in_ok;
  assign sel_ctrl.shift = rd_valid;
  assign sel_ctrl.step  = (state_r == ST_SELECT);

  mdn_store #(
    .CHANNELS     (CHANNELS),
    .WINDOW_LIMIT (WINDOW_LIMIT)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (store_ctrl),
    .ch       (store_ch),
    .len      (in_ch.window_len),
    .wr_data  (in_ch.sample),
    .rd_idx   (idx_r),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  mdn_select #(
    .WINDOW_LIMIT (WINDOW_LIMIT)
  ) u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (sel_ctrl),
    .len        (in_ch.window_len),
    .shift_data (rd_data),
    .result     (sel_result)
  );

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    len_nxt   = len_r;
    inv_nxt   = inv_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ch_nxt    = CH_W'(in_ch.channel);
          len_nxt   = in_ch.window_len;
          inv_nxt   = !in_ok;
          idx_nxt   = '0;
          state_nxt = in_ok ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        idx_nxt = idx_r + WIN_W'(1);
        if (32'(idx_r) + 32'd1 == 32'(len_r)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The last slot read is shifted into the lanes in this cycle.
        step_nxt  = '0;
        state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: holds the result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    median_nxt    = median_r;
    invalid_nxt   = invalid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      median_nxt    = inv_r ? '0 : sel_result;
      invalid_nxt   = inv_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    len_r     <= len_nxt;
    inv_r     <= inv_nxt;
    idx_r     <= idx_nxt;
    step_r    <= step_nxt;
    median_r  <= median_nxt;
    invalid_r <= invalid_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.median  = median_r;
  assign out_ch.invalid = invalid_r;

  // An out-of-range transaction skips the memory and selection entirely.
  a_invalid_skips : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ok |=> state_r == ST_DONE && inv_r)
    else $error("invalid transaction did not go straight to result handover");

  // Reads never go beyond the window length that was captured.
  a_read_in_window : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> 32'(idx_r) < 32'(len_r))
    else $error("memory read beyond the window length");

  // Read data only arrives while the lanes are being filled.
  a_shift_in_load : assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> state_r == ST_LOAD || state_r == ST_FLUSH)
    else $error("lane shift outside the load phase");

endmodule
